// ===== rtl/egcd_pkg.sv =====
// Package for the extended GCD block: widths, sequencer states and the
// control/status structs shared by the sequencer and the datapath.
// No dependencies.
package egcd_pkg;

  localparam int DATA_WIDTH  = 32;
  localparam int COEF_WIDTH  = DATA_WIDTH + 1;
  localparam int ACC_WIDTH   = DATA_WIDTH + 3;
  localparam int CNT_WIDTH   = $clog2(DATA_WIDTH);
  localparam int IN_BITS     = 2 * DATA_WIDTH;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS    = 2 * COEF_WIDTH + DATA_WIDTH;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ALIGN,
    ST_DIV,
    ST_UPDATE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic align_shift;
    logic div_step;
    logic update;
  } ctrl_t;

  typedef struct packed {
    logic b_zero;
    logic shift_ok;
    logic cnt_zero;
    logic rem_zero;
  } status_t;

endpackage

// ===== rtl/egcd_datapath.sv =====
// Shared shift-subtract unit of the extended GCD block: remainder, divisor,
// quotient-weighted coefficient accumulators and the Bezout coefficients.
// Depends on egcd_pkg.
module egcd_datapath (
  input  logic                                clk,
  input  egcd_pkg::ctrl_t                     ctrl,
  input  logic [egcd_pkg::DATA_WIDTH-1:0]     operand_a,
  input  logic [egcd_pkg::DATA_WIDTH-1:0]     operand_b,
  output egcd_pkg::status_t                   status,
  output logic signed [egcd_pkg::COEF_WIDTH-1:0] coeff_x,
  output logic signed [egcd_pkg::COEF_WIDTH-1:0] coeff_y,
  output logic [egcd_pkg::DATA_WIDTH-1:0]     gcd_value
);

  localparam int W  = egcd_pkg::DATA_WIDTH;
  localparam int CW = egcd_pkg::COEF_WIDTH;
  localparam int AW = egcd_pkg::ACC_WIDTH;

  logic [W-1:0] rem;
  logic [W-1:0] bcur;
  logic [W-1:0] dvs;
  logic [egcd_pkg::CNT_WIDTH-1:0] cnt;
  logic signed [CW-1:0] xp, xc, yp, yc;
  logic signed [AW-1:0] accx, accy;

  logic [W:0] dvs2;
  logic       ge;
  logic signed [AW-1:0] xc_ext, yc_ext, xn, yn;

  always_comb begin
    dvs2   = {dvs, 1'b0};
    ge     = rem >= dvs;
    xc_ext = {{(AW-CW){xc[CW-1]}}, xc};
    yc_ext = {{(AW-CW){yc[CW-1]}}, yc};
    xn     = {{(AW-CW){xp[CW-1]}}, xp} - accx;
    yn     = {{(AW-CW){yp[CW-1]}}, yp} - accy;
  end

  assign status.b_zero   = operand_b == '0;
  assign status.shift_ok = dvs2 <= {1'b0, rem};
  assign status.cnt_zero = cnt == '0;
  assign status.rem_zero = rem == '0;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      rem  <= operand_a;
      bcur <= operand_b;
      dvs  <= operand_b;
      cnt  <= '0;
      accx <= '0;
      accy <= '0;
      xp   <= CW'(1);
      xc   <= '0;
      yp   <= '0;
      yc   <= CW'(1);
    end else if (ctrl.align_shift) begin
      dvs <= dvs2[W-1:0];
      cnt <= cnt + 1'b1;
    end else if (ctrl.div_step) begin
      // Quotient bits arrive MSB first, so q*xc builds up Horner style.
      if (ge) begin
        rem <= rem - dvs;
      end
      accx <= (accx <<< 1) + (ge ? xc_ext : '0);
      accy <= (accy <<< 1) + (ge ? yc_ext : '0);
      dvs  <= dvs >> 1;
      if (cnt != '0) begin
        cnt <= cnt - 1'b1;
      end
    end else if (ctrl.update) begin
      rem  <= bcur;
      bcur <= rem;
      dvs  <= rem;
      cnt  <= '0;
      accx <= '0;
      accy <= '0;
      xp   <= xc;
      xc   <= xn[CW-1:0];
      yp   <= yc;
      yc   <= yn[CW-1:0];
    end
  end

  assign coeff_x   = xp;
  assign coeff_y   = yp;
  assign gcd_value = rem;

endmodule

// ===== rtl/egcd_ctrl.sv =====
// Sequencer of the extended GCD block: steps the shared unit through
// alignment, division and coefficient update for each Euclid step.
// Depends on egcd_pkg.
module egcd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              out_free,
  input  egcd_pkg::status_t status,
  output egcd_pkg::ctrl_t   ctrl,
  output logic              in_ready,
  output logic              finish
);

  egcd_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= egcd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctrl       = '0;
    in_ready   = 1'b0;
    finish     = 1'b0;
    unique case (state)
      egcd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctrl.load  = 1'b1;
          state_next = status.b_zero ? egcd_pkg::ST_FINISH : egcd_pkg::ST_ALIGN;
        end
      end
      egcd_pkg::ST_ALIGN: begin
        if (status.shift_ok) begin
          ctrl.align_shift = 1'b1;
        end else begin
          state_next = egcd_pkg::ST_DIV;
        end
      end
      egcd_pkg::ST_DIV: begin
        ctrl.div_step = 1'b1;
        if (status.cnt_zero) begin
          state_next = egcd_pkg::ST_UPDATE;
        end
      end
      egcd_pkg::ST_UPDATE: begin
        ctrl.update = 1'b1;
        state_next  = status.rem_zero ? egcd_pkg::ST_FINISH : egcd_pkg::ST_ALIGN;
      end
      egcd_pkg::ST_FINISH: begin
        if (out_free) begin
          finish     = 1'b1;
          state_next = egcd_pkg::ST_IDLE;
        end
      end
      default: state_next = egcd_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/extended_gcd_top.sv =====
// Extended GCD block, top level: stream ports, sequencer, shared unit, output word.
// A zero operand_b skips the Euclid steps and goes straight to the result. The block
// takes one word at a time; the input is not ready until the result moves to the
// output register, as the single shift-subtract unit serves every step. Reset (rst,
// synchronous, active high) returns the sequencer to idle and empties the output register.
module extended_gcd_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // s_tdata fields, low bit up: operand_a, operand_b
  input  logic [egcd_pkg::IN_TDATA_W-1:0]    s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // m_tdata fields, low bit up: coeff_x, coeff_y, gcd_value, zero padding
  output logic [egcd_pkg::OUT_TDATA_W-1:0]   m_tdata
);

  localparam int W  = egcd_pkg::DATA_WIDTH;
  localparam int CW = egcd_pkg::COEF_WIDTH;

  egcd_pkg::ctrl_t   ctrl;
  egcd_pkg::status_t status;
  logic              finish;
  logic              out_free;

  logic [W-1:0]         operand_a, operand_b;
  logic signed [CW-1:0] dp_x, dp_y;
  logic [W-1:0]         dp_gcd;

  logic signed [CW-1:0] out_x, out_y;
  logic [W-1:0]         out_gcd;

  assign operand_a = s_tdata[W-1:0];
  assign operand_b = s_tdata[2*W-1:W];

  // The output register can take a new result when empty or being drained.
  assign out_free = !m_tvalid || m_tready;

  egcd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .out_free (out_free),
    .status   (status),
    .ctrl     (ctrl),
    .in_ready (s_tready),
    .finish   (finish)
  );

  egcd_datapath u_datapath (
    .clk       (clk),
    .ctrl      (ctrl),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .status    (status),
    .coeff_x   (dp_x),
    .coeff_y   (dp_y),
    .gcd_value (dp_gcd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Payload holds no reset; it is loaded only when a result completes.
  always_ff @(posedge clk) begin
    if (finish) begin
      out_x   <= dp_x;
      out_y   <= dp_y;
      out_gcd <= dp_gcd;
    end
  end

  assign m_tdata = {{(egcd_pkg::OUT_TDATA_W - egcd_pkg::OUT_BITS){1'b0}},
                    out_gcd, out_y, out_x};

  // A word taken in makes the block busy on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input ready right after accepting a word");

  // A zero operand_b bypasses the iteration and yields x = 1, y = 0.
  a_b_zero_shortcut: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && operand_b == '0 && !m_tvalid) |=> ##1
    (m_tvalid && out_x == CW'(1) && out_y == '0 && out_gcd == $past(operand_a, 2)))
    else $error("zero divisor shortcut gave a wrong result");

  // A zero gcd arises only from a = b = 0, whose coefficients are 1 and 0.
  a_zero_gcd: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_gcd == '0) |-> (out_x == CW'(1) && out_y == '0))
    else $error("zero gcd with wrong coefficients");

  // A result is not overwritten while it waits to be taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !finish)
    else $error("result overwritten before it was taken");

endmodule

// ===== sim/tb_extended_gcd_top.sv =====
// Testbench for extended_gcd_top: drives operand pairs on the input stream and checks each
// gcd and Bezout pair on the output stream against an in-bench extended Euclid predictor.
// Depends on egcd_pkg and extended_gcd_top from the rtl folder.
module tb_extended_gcd_top;

  localparam int DATA_WIDTH  = egcd_pkg::DATA_WIDTH;
  localparam int COEF_WIDTH  = egcd_pkg::COEF_WIDTH;
  localparam int IN_TDATA_W  = egcd_pkg::IN_TDATA_W;
  localparam int OUT_TDATA_W = egcd_pkg::OUT_TDATA_W;

  // One result word, unpacked into its fields.
  typedef struct packed {
    logic [COEF_WIDTH-1:0] coeff_x;
    logic [COEF_WIDTH-1:0] coeff_y;
    logic [DATA_WIDTH-1:0] gcd_value;
  } bezout_t;

  // One row of the directed table. Rows with known set carry a hand-written answer;
  // the others are checked against the predictor.
  typedef struct packed {
    logic [DATA_WIDTH-1:0] operand_a;
    logic [DATA_WIDTH-1:0] operand_b;
    logic                  known;
    bezout_t               answer;
  } operand_row_t;

  localparam int      NUM_ROWS     = 20;
  localparam int      RANDOM_WORDS = 1250;
  localparam int      DRAIN_CYCLES = 400;
  localparam int      FIB_LAST     = 47;
  localparam bezout_t UNTYPED      = '0;

  logic                   clk      = 1'b0;
  logic                   rst      = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata  = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  bezout_t               pending_results[$];
  int                    mismatch_count = 0;
  int                    send_idle_pct  = 0;
  int                    recv_idle_pct  = 0;
  logic [DATA_WIDTH-1:0] fib [0:FIB_LAST];

  // Extremes, the zero-operand cases and consecutive Fibonacci numbers, which take the
  // most division steps and give the largest coefficients.
  operand_row_t directed_rows [NUM_ROWS] = '{
    '{32'h0000_0000, 32'h0000_0000, 1'b1, '{33'd1, 33'd0, 32'h0000_0000}},
    '{32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{33'd1, 33'd0, 32'hFFFF_FFFF}},
    '{32'h0000_0000, 32'hFFFF_FFFF, 1'b1, '{33'd0, 33'd1, 32'hFFFF_FFFF}},
    '{32'h0000_0000, 32'h0000_0001, 1'b1, '{33'd0, 33'd1, 32'h0000_0001}},
    '{32'h0000_0001, 32'h0000_0000, 1'b1, '{33'd1, 33'd0, 32'h0000_0001}},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{33'd0, 33'd1, 32'hFFFF_FFFF}},
    '{32'h0000_0001, 32'h0000_0001, 1'b1, '{33'd0, 33'd1, 32'h0000_0001}},
    '{32'hFFFF_FFFF, 32'h0000_0001, 1'b1, '{33'd0, 33'd1, 32'h0000_0001}},
    '{32'h0000_0001, 32'hFFFF_FFFF, 1'b1, '{33'd1, 33'd0, 32'h0000_0001}},
    '{32'h0000_0007, 32'h0000_0007, 1'b1, '{33'd0, 33'd1, 32'h0000_0007}},
    '{32'd240,        32'd46,        1'b0, UNTYPED},
    '{32'd46,         32'd240,       1'b0, UNTYPED},
    '{32'd2971215073, 32'd1836311903, 1'b0, UNTYPED},
    '{32'd1836311903, 32'd2971215073, 1'b0, UNTYPED},
    '{32'hAAAA_AAAA, 32'h5555_5555, 1'b0, UNTYPED},
    '{32'h8000_0000, 32'h7FFF_FFFF, 1'b0, UNTYPED},
    '{32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b0, UNTYPED},
    '{32'd12,         32'd8,          1'b0, UNTYPED},
    '{32'h9E37_79B9, 32'h7F4A_7C15, 1'b0, UNTYPED},
    '{32'h0003_0000, 32'h0005_0000, 1'b0, UNTYPED}
  };

  extended_gcd_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  // Quotient-remainder iteration. Coefficients run modulo 2^64 and the true values fit
  // in the coefficient width, so the low bits are exact. A zero b skips the loop and
  // leaves d = a, x = 1, y = 0.
  function automatic bezout_t solve_bezout(input logic [DATA_WIDTH-1:0] op_a,
                                           input logic [DATA_WIDTH-1:0] op_b);
    logic [63:0] rem_prev, rem_cur, quot, rem_next;
    logic [63:0] x_prev, x_cur, x_next, y_prev, y_cur, y_next;
    bezout_t     res;
    rem_prev = 64'(op_a);
    rem_cur  = 64'(op_b);
    x_prev   = 64'd1;
    x_cur    = 64'd0;
    y_prev   = 64'd0;
    y_cur    = 64'd1;
    while (rem_cur != 64'd0) begin
      quot     = rem_prev / rem_cur;
      rem_next = rem_prev - quot * rem_cur;
      x_next   = x_prev - quot * x_cur;
      y_next   = y_prev - quot * y_cur;
      rem_prev = rem_cur;
      rem_cur  = rem_next;
      x_prev   = x_cur;
      x_cur    = x_next;
      y_prev   = y_cur;
      y_cur    = y_next;
    end
    res.coeff_x   = x_prev[COEF_WIDTH-1:0];
    res.coeff_y   = y_prev[COEF_WIDTH-1:0];
    res.gcd_value = rem_prev[DATA_WIDTH-1:0];
    return res;
  endfunction

  // Picks one operand pair. Full random words cover every bit; the other shapes aim at
  // long Euclid chains, shared factors, zeros, multiples and uneven magnitudes.
  task automatic pick_operands(output logic [DATA_WIDTH-1:0] op_a,
                               output logic [DATA_WIDTH-1:0] op_b);
    int                    shape;
    int                    idx;
    logic [DATA_WIDTH-1:0] factor;
    shape = $urandom_range(99);
    if (shape < 40) begin
      op_a = $urandom;
      op_b = $urandom;
    end else if (shape < 55) begin
      idx  = $urandom_range(1, FIB_LAST - 1);
      op_a = fib[idx + 1];
      op_b = fib[idx];
    end else if (shape < 70) begin
      factor = $urandom_range(2, 65535);
      op_a   = factor * $urandom_range(1, 65535);
      op_b   = factor * $urandom_range(1, 65535);
    end else if (shape < 80) begin
      op_a = $urandom_range(0, 255);
      op_b = $urandom_range(0, 255);
    end else if (shape < 87) begin
      op_a = $urandom;
      op_b = '0;
    end else if (shape < 93) begin
      op_b = $urandom_range(1, 65535);
      op_a = ($urandom_range(3) == 0) ? op_b : op_b * $urandom_range(1, 65535);
    end else begin
      op_a = $urandom >> $urandom_range(31);
      op_b = $urandom >> $urandom_range(31);
    end
    if ($urandom_range(1) == 1) begin
      {op_a, op_b} = {op_b, op_a};
    end
  endtask

  // Offers one word and returns at the falling edge after it was taken. Entered at a
  // falling edge. Valid only drops when the sender decides to idle before the next word.
  task automatic send_operands(input logic [DATA_WIDTH-1:0] op_a,
                               input logic [DATA_WIDTH-1:0] op_b,
                               input logic                  known,
                               input bezout_t               answer);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_TDATA_W'({op_b, op_a});
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(known ? answer : solve_bezout(op_a, op_b));
    @(negedge clk);
  endtask

  task automatic report_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // Receiver back-pressure, redrawn every cycle.
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Every accepted result word is held against the oldest outstanding expectation.
  always @(posedge clk) begin : result_check
    bezout_t seen;
    bezout_t want;
    if (!rst && m_tvalid && m_tready) begin
      seen.coeff_x   = m_tdata[COEF_WIDTH-1:0];
      seen.coeff_y   = m_tdata[2*COEF_WIDTH-1:COEF_WIDTH];
      seen.gcd_value = m_tdata[2*COEF_WIDTH+DATA_WIDTH-1:2*COEF_WIDTH];
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result word, expected none, actual %h", $time, seen);
      end else begin
        want = pending_results.pop_front();
        report_field("coeff_x", 64'(want.coeff_x), 64'(seen.coeff_x));
        report_field("coeff_y", 64'(want.coeff_y), 64'(seen.coeff_y));
        report_field("gcd_value", 64'(want.gcd_value), 64'(seen.gcd_value));
      end
    end
  end

  initial begin : stimulus
    logic [DATA_WIDTH-1:0] op_a;
    logic [DATA_WIDTH-1:0] op_b;
    int                    phase;
    int                    n;
    fib[0] = '0;
    fib[1] = 1;
    for (int i = 2; i <= FIB_LAST; i++) begin
      fib[i] = fib[i - 1] + fib[i - 2];
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table under the first idling mix.
    send_idle_pct = 27;
    recv_idle_pct = 68;
    foreach (directed_rows[i]) begin
      send_operands(directed_rows[i].operand_a, directed_rows[i].operand_b,
                    directed_rows[i].known, directed_rows[i].answer);
    end

    // Random words in three idling phases: sender light and receiver heavy, then
    // swapped, then both sides at full rate.
    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 27 : (phase == 1) ? 68 : 0;
      recv_idle_pct = (phase == 0) ? 68 : (phase == 1) ? 27 : 0;
      for (n = 0; n < RANDOM_WORDS / 3; n++) begin
        pick_operands(op_a, op_b);
        send_operands(op_a, op_b, 1'b0, UNTYPED);
      end
    end
    s_tvalid <= 1'b0;

    wait (pending_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("extended_gcd_top test passed");
    end else begin
      $display("extended_gcd_top test failed");
    end
    $finish;
  end

  // Watchdog, several times the slowest correct run.
  initial begin
    #50_000_000;
    $display("extended_gcd_top test failed");
    $finish;
  end

endmodule
